// ----- sv/sfr_pkg.sv -----
`timescale 1ns / 1ps

package sfr_pkg;

    // frame marker bytes
    localparam logic [7:0] SYNC_A        = 8'hC5;
    localparam logic [7:0] SYNC_B        = 8'hC3;
    localparam logic [7:0] FRAME_VERSION = 8'h01;
    localparam logic [7:0] SUM_GOOD      = 8'hFF;

    // input opcodes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // result kinds
    localparam logic [2:0] KIND_DATA    = 3'd0;
    localparam logic [2:0] KIND_GOOD    = 3'd1;
    localparam logic [2:0] KIND_BADSUM  = 3'd2;
    localparam logic [2:0] KIND_BIG     = 3'd3;
    localparam logic [2:0] KIND_TIMEOUT = 3'd4;

    // configuration register indexes
    localparam logic CFG_TIMEOUT = 1'b0;
    localparam logic CFG_MAXLEN  = 1'b1;

    // configuration reset values
    localparam logic [31:0] TIMEOUT_RESET = 32'd1000;
    localparam logic [15:0] MAXLEN_RESET  = 16'd256;

    // classified item handed from front to back
    typedef struct packed {
        logic       is_tick;
        logic       sync_a;
        logic       sync_b;
        logic       version;
        logic [7:0] rx_byte;
    } sfr_item_t;

endpackage

// ----- sv/sfr_front.sv -----
`timescale 1ns / 1ps

module sfr_front (
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // rx_byte
    input  logic              s_axis_tuser,   // opcode
    input  logic              queue_full,
    output logic              push_valid,
    output sfr_pkg::sfr_item_t push_item
);
    import sfr_pkg::*;

    // accept whenever the queue has room
    assign s_axis_tready = !queue_full;
    assign push_valid    = s_axis_tvalid && !queue_full;

    // classify the byte against the frame markers
    always_comb begin
        push_item.is_tick = (s_axis_tuser == OP_TICK);
        push_item.sync_a  = (s_axis_tdata == SYNC_A);
        push_item.sync_b  = (s_axis_tdata == SYNC_B);
        push_item.version = (s_axis_tdata == FRAME_VERSION);
        push_item.rx_byte = s_axis_tdata;
    end

endmodule

// ----- sv/sfr_queue.sv -----
`timescale 1ns / 1ps

module sfr_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_valid,
    input  sfr_pkg::sfr_item_t push_item,
    output logic               full,
    input  logic               pop,
    output logic               pop_valid,
    output sfr_pkg::sfr_item_t pop_item
);
    import sfr_pkg::*;

    sfr_item_t  slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_item  = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = push_valid ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push_valid} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push_valid) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

`ifndef SYNTHESIS
    a_no_push_full : assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push_valid)
        else $error("push into full queue");
    a_no_pop_empty : assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> pop_valid)
        else $error("pop from empty queue");
    a_count_range : assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("queue count out of range");
`endif

endmodule

// ----- sv/sfr_back.sv -----
`timescale 1ns / 1ps

module sfr_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  sfr_pkg::sfr_item_t q_item,
    output logic               q_pop,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_addr,
    input  logic [31:0]        cfg_data,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [39:0]        m_axis_tdata,   // data_byte, frame_intent, payload_count
    output logic [2:0]         m_axis_tuser    // kind
);
    import sfr_pkg::*;

    // parser state codes
    localparam logic [3:0] ST_HUNT    = 4'd0;
    localparam logic [3:0] ST_SYNC_B  = 4'd1;
    localparam logic [3:0] ST_VERSION = 4'd2;
    localparam logic [3:0] ST_FLAGS   = 4'd3;
    localparam logic [3:0] ST_LEN_LO  = 4'd4;
    localparam logic [3:0] ST_LEN_HI  = 4'd5;
    localparam logic [3:0] ST_INT_LO  = 4'd6;
    localparam logic [3:0] ST_INT_HI  = 4'd7;
    localparam logic [3:0] ST_PAYLOAD = 4'd8;
    localparam logic [3:0] ST_CHECK   = 4'd9;

    logic [31:0] timeout_reg;
    logic [15:0] maxlen_reg;

    logic [3:0]  state_reg, state_next;
    logic [15:0] remaining_reg, remaining_next;
    logic [15:0] intent_reg, intent_next;
    logic [7:0]  sum_reg, sum_next;
    logic [31:0] elapsed_reg, elapsed_next;
    logic [15:0] count_reg, count_next;

    logic        m_valid_reg, m_valid_next;
    logic [2:0]  kind_reg, kind_next;
    logic [7:0]  data_reg, data_next;
    logic [15:0] out_intent_reg, out_intent_next;
    logic [15:0] out_count_reg, out_count_next;

    logic [3:0]  st_work;
    logic        emit;
    logic [15:0] length_full;
    logic [15:0] count_inc;

    assign cfg_ready     = 1'b1;
    assign q_pop         = q_valid && (!m_valid_reg || m_axis_tready);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = kind_reg;
    assign m_axis_tdata  = {out_count_reg, out_intent_reg, data_reg};

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
            maxlen_reg  <= MAXLEN_RESET;
        end else if (cfg_valid) begin
            case (cfg_addr)
                CFG_TIMEOUT: timeout_reg <= cfg_data;
                CFG_MAXLEN:  maxlen_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // parser step for the item at the head of the queue
    always_comb begin
        state_next      = state_reg;
        remaining_next  = remaining_reg;
        intent_next     = intent_reg;
        sum_next        = sum_reg;
        elapsed_next    = elapsed_reg;
        count_next      = count_reg;
        kind_next       = kind_reg;
        data_next       = data_reg;
        out_intent_next = out_intent_reg;
        out_count_next  = out_count_reg;
        st_work         = state_reg;
        emit            = 1'b0;
        length_full     = {q_item.rx_byte, remaining_reg[7:0]};
        count_inc       = (count_reg != 16'hFFFF) ? count_reg + 16'd1 : count_reg;

        if (q_pop) begin
            if (q_item.is_tick) begin
                // elapsed time only runs inside a frame and saturates
                if (state_reg != ST_HUNT && elapsed_reg != 32'hFFFF_FFFF) begin
                    elapsed_next = elapsed_reg + 32'd1;
                end
            end else begin
                // timeout drops the frame, then the byte is parsed from hunt
                if (state_reg != ST_HUNT && timeout_reg != 32'd0
                        && elapsed_reg > timeout_reg) begin
                    emit           = 1'b1;
                    kind_next      = KIND_TIMEOUT;
                    data_next      = 8'd0;
                    out_intent_next = 16'd0;
                    out_count_next = count_reg;
                    st_work        = ST_HUNT;
                end

                sum_next = (st_work == ST_HUNT) ? q_item.rx_byte
                                                : sum_reg + q_item.rx_byte;

                case (st_work)
                    ST_HUNT: begin
                        if (q_item.sync_a) begin
                            elapsed_next = 32'd0;
                            count_next   = 16'd0;
                            state_next   = ST_SYNC_B;
                        end else begin
                            state_next = ST_HUNT;
                        end
                    end
                    ST_SYNC_B:  state_next = q_item.sync_b ? ST_VERSION : ST_HUNT;
                    ST_VERSION: state_next = q_item.version ? ST_FLAGS : ST_HUNT;
                    ST_FLAGS:   state_next = ST_LEN_LO;
                    ST_LEN_LO: begin
                        remaining_next = {8'd0, q_item.rx_byte};
                        state_next     = ST_LEN_HI;
                    end
                    ST_LEN_HI: begin
                        remaining_next = length_full;
                        if (length_full > maxlen_reg) begin
                            state_next      = ST_HUNT;
                            emit            = 1'b1;
                            kind_next       = KIND_BIG;
                            data_next       = 8'd0;
                            out_intent_next = 16'd0;
                            out_count_next  = 16'd0;
                        end else begin
                            state_next = ST_INT_LO;
                        end
                    end
                    ST_INT_LO: begin
                        intent_next = {8'd0, q_item.rx_byte};
                        state_next  = ST_INT_HI;
                    end
                    ST_INT_HI: begin
                        intent_next = {q_item.rx_byte, intent_reg[7:0]};
                        state_next  = (remaining_reg != 16'd0) ? ST_PAYLOAD : ST_CHECK;
                    end
                    ST_PAYLOAD: begin
                        count_next      = count_inc;
                        emit            = 1'b1;
                        kind_next       = KIND_DATA;
                        data_next       = q_item.rx_byte;
                        out_intent_next = 16'd0;
                        out_count_next  = count_inc;
                        remaining_next  = remaining_reg - 16'd1;
                        state_next      = (remaining_reg == 16'd1) ? ST_CHECK : ST_PAYLOAD;
                    end
                    ST_CHECK: begin
                        state_next      = ST_HUNT;
                        emit            = 1'b1;
                        kind_next       = (sum_next == SUM_GOOD) ? KIND_GOOD : KIND_BADSUM;
                        data_next       = 8'd0;
                        out_intent_next = intent_reg;
                        out_count_next  = count_reg;
                    end
                    default: state_next = ST_HUNT;
                endcase
            end
        end
    end

    // output register: a pop loads the item's result, if it has one; a transfer alone empties it
    always_comb begin
        if (q_pop) begin
            m_valid_next = emit;
        end else begin
            m_valid_next = m_valid_reg && !m_axis_tready;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_HUNT;
            remaining_reg <= 16'd0;
            intent_reg    <= 16'd0;
            sum_reg       <= 8'd0;
            elapsed_reg   <= 32'd0;
            count_reg     <= 16'd0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            remaining_reg <= remaining_next;
            intent_reg    <= intent_next;
            sum_reg       <= sum_next;
            elapsed_reg   <= elapsed_next;
            count_reg     <= count_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (q_pop && emit) begin
            kind_reg       <= kind_next;
            data_reg       <= data_next;
            out_intent_reg <= out_intent_next;
            out_count_reg  <= out_count_next;
        end
    end

`ifndef SYNTHESIS
    a_state_range : assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg <= ST_CHECK)
        else $error("parser state out of range");
    a_kind_range : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> kind_reg <= KIND_TIMEOUT)
        else $error("result kind out of range");
    a_tick_silent : assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_item.is_tick) |=> !m_valid_reg)
        else $error("tick produced a result");
    a_data_counted : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && kind_reg == KIND_DATA) |-> out_count_reg != 16'd0)
        else $error("payload byte with zero count");
`endif

endmodule

// ----- sv/serial_frame_receiver_unit.sv -----
`timescale 1ns / 1ps
// path: an input item waits in a queue slot, then the parser puts its result in the output register
// throughput: one byte or tick per cycle unless m_axis stalls; the single parser step per item sets the rate
// ticks and non-reporting bytes give no result; at most one result per item
// reset: aresetn is synchronous, active low; parser returns to sync hunt, queue and
// output empty, timeout_ms to 1000 and max_length to 256

module serial_frame_receiver_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    input  logic        s_axis_tuser,   // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // data_byte, frame_intent, payload_count
    output logic [2:0]  m_axis_tuser,   // kind
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_addr,
    input  logic [31:0] cfg_data
);
    import sfr_pkg::*;

    logic      push_valid;
    sfr_item_t push_item;
    logic      queue_full;
    logic      q_pop;
    logic      q_valid;
    sfr_item_t q_item;

    // input side: accept and classify
    sfr_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .queue_full    (queue_full),
        .push_valid    (push_valid),
        .push_item     (push_item)
    );

    // two-entry queue between the sides
    sfr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_item   (q_item)
    );

    // frame parser and result register
    sfr_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    import sfr_pkg::*;

    // parser states as the frame layout defines them
    typedef enum logic [3:0] {
        PS_HUNT, PS_SYNC_B, PS_VERSION, PS_FLAGS, PS_LEN_LO, PS_LEN_HI,
        PS_INT_LO, PS_INT_HI, PS_PAYLOAD, PS_CHECK
    } parse_state_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data_byte;
        logic [15:0] frame_intent;
        logic [15:0] payload_count;
    } frame_result_t;

    logic        aclk;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;   // rx_byte
    logic        s_axis_tuser  = 1'b0;    // opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;            // data_byte, frame_intent, payload_count
    logic [2:0]  m_axis_tuser;            // kind
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic        cfg_addr      = 1'b0;
    logic [31:0] cfg_data      = 32'h0;

    // predicted parser state and configuration
    logic [31:0]  tmo_limit  = TIMEOUT_RESET;
    logic [15:0]  len_limit  = MAXLEN_RESET;
    parse_state_t ps         = PS_HUNT;
    logic [15:0]  remaining  = 16'h0;
    logic [15:0]  intent     = 16'h0;
    logic [7:0]   frame_sum  = 8'h0;
    logic [31:0]  ticks      = 32'h0;
    logic [15:0]  rx_count   = 16'h0;

    frame_result_t expected_results[$];
    bit            idle_on       = 1'b0;
    int            errors        = 0;
    int            items_sent    = 0;
    int            settings_used = 1;
    int            kind_seen[5]  = '{default: 0};

    serial_frame_receiver_unit i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("timeout waiting for the block");
        $display("simulation failed");
        $finish;
    end

    // one parser step per accepted item, pushing the result it causes
    function void parse_step(input logic op, input logic [7:0] b);
        frame_result_t r;
        r = '0;
        if (op == OP_TICK) begin
            if (ps != PS_HUNT && ticks != 32'hFFFF_FFFF) ticks = ticks + 32'd1;
            return;
        end
        // stale frame is dropped, the byte is then parsed from hunt
        if (ps != PS_HUNT && tmo_limit != 32'd0 && ticks > tmo_limit) begin
            r.kind = KIND_TIMEOUT;
            r.payload_count = rx_count;
            expected_results.push_back(r);
            ps = PS_HUNT;
        end
        if (ps == PS_HUNT) frame_sum = b;
        else frame_sum = frame_sum + b;
        case (ps)
            PS_HUNT: begin
                if (b == SYNC_A) begin
                    ticks = 32'd0;
                    rx_count = 16'd0;
                    ps = PS_SYNC_B;
                end
            end
            PS_SYNC_B: begin
                if (b == SYNC_B) ps = PS_VERSION;
                else ps = PS_HUNT;
            end
            PS_VERSION: begin
                if (b == FRAME_VERSION) ps = PS_FLAGS;
                else ps = PS_HUNT;
            end
            PS_FLAGS: ps = PS_LEN_LO;
            PS_LEN_LO: begin
                remaining = {8'h00, b};
                ps = PS_LEN_HI;
            end
            PS_LEN_HI: begin
                remaining = {b, remaining[7:0]};
                if (remaining > len_limit) begin
                    r = '0;
                    r.kind = KIND_BIG;
                    expected_results.push_back(r);
                    ps = PS_HUNT;
                end else begin
                    ps = PS_INT_LO;
                end
            end
            PS_INT_LO: begin
                intent = {8'h00, b};
                ps = PS_INT_HI;
            end
            PS_INT_HI: begin
                intent = {b, intent[7:0]};
                if (remaining != 16'd0) ps = PS_PAYLOAD;
                else ps = PS_CHECK;
            end
            PS_PAYLOAD: begin
                if (rx_count != 16'hFFFF) rx_count = rx_count + 16'd1;
                r = '0;
                r.kind = KIND_DATA;
                r.data_byte = b;
                r.payload_count = rx_count;
                expected_results.push_back(r);
                remaining = remaining - 16'd1;
                if (remaining == 16'd0) ps = PS_CHECK;
            end
            PS_CHECK: begin
                r = '0;
                r.kind = (frame_sum == SUM_GOOD) ? KIND_GOOD : KIND_BADSUM;
                r.frame_intent = intent;
                r.payload_count = rx_count;
                expected_results.push_back(r);
                ps = PS_HUNT;
            end
            default: ps = PS_HUNT;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    // result checker
    always @(posedge aclk) begin : check_result
        frame_result_t got;
        frame_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.kind          = m_axis_tuser;
            got.data_byte     = m_axis_tdata[7:0];
            got.frame_intent  = m_axis_tdata[23:8];
            got.payload_count = m_axis_tdata[39:24];
            if (got.kind <= KIND_TIMEOUT) kind_seen[got.kind]++;
            if (expected_results.size() == 0) begin
                report_mismatch("result with none pending, kind", 32'(got.kind), 32'h0);
            end else begin
                want = expected_results.pop_front();
                if (got.kind != want.kind)
                    report_mismatch("kind", 32'(got.kind), 32'(want.kind));
                if (got.data_byte != want.data_byte)
                    report_mismatch("data_byte", 32'(got.data_byte), 32'(want.data_byte));
                if (got.frame_intent != want.frame_intent)
                    report_mismatch("frame_intent", 32'(got.frame_intent),
                                    32'(want.frame_intent));
                if (got.payload_count != want.payload_count)
                    report_mismatch("payload_count", 32'(got.payload_count),
                                    32'(want.payload_count));
            end
        end
    end

    // receiver stalls
    always @(posedge aclk) begin
        m_axis_tready <= !idle_on || ($urandom_range(99) >= 32);
    end

    // one input transfer, with an optional gap ahead of it
    task automatic send_item(input logic op, input logic [7:0] b);
        if (idle_on && $urandom_range(99) < 32) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= op;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        parse_step(op, b);
        items_sent++;
    endtask

    // sender stops until every pending result has been taken
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_TIMEOUT) tmo_limit = value;
        else len_limit = value[15:0];
        @(posedge aclk);
    endtask

    // frame with random flags and payload; cut keeps only the first bytes
    task automatic send_frame(input logic [15:0] len, input logic [15:0] fr_intent,
                              input bit bad_sum, input int cut, input int tick_pct);
        logic [7:0] frame_bytes[$];
        logic [7:0] sum;
        int         n_payload;
        int         n_send;
        n_payload = (cut != 0 && cut <= 8) ? 0 : len;
        frame_bytes = {SYNC_A, SYNC_B, FRAME_VERSION, 8'($urandom),
                       len[7:0], len[15:8], fr_intent[7:0], fr_intent[15:8]};
        for (int i = 0; i < n_payload; i++) frame_bytes.push_back(8'($urandom));
        sum = 8'h00;
        foreach (frame_bytes[i]) sum = sum + frame_bytes[i];
        sum = SUM_GOOD - sum;
        if (bad_sum) sum = sum + 8'($urandom_range(1, 255));
        frame_bytes.push_back(sum);
        n_send = (cut == 0 || cut > frame_bytes.size()) ? frame_bytes.size() : cut;
        for (int i = 0; i < n_send; i++) begin
            if ($urandom_range(99) < tick_pct) send_item(OP_TICK, 8'($urandom));
            send_item(OP_BYTE, frame_bytes[i]);
        end
    endtask

    // frames under reset configuration, bad markers, zero length, an oversized length
    task automatic test_reset_config_frames();
        send_frame(16'd2, 16'h1234, 1'b0, 0, 0);
        send_frame(16'd0, 16'hFFFF, 1'b1, 0, 0);
        send_item(OP_BYTE, SYNC_A);
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, SYNC_A);
        send_item(OP_BYTE, SYNC_B);
        send_item(OP_BYTE, 8'h02);
        send_frame(16'd257, 16'h0000, 1'b0, 6, 0);
    endtask

    // timeout restarts on the same byte, hunt ignores ticks, zero disables
    task automatic test_timeout_rules();
        wait_idle();
        write_reg(CFG_TIMEOUT, 32'd1);
        write_reg(CFG_MAXLEN, 32'h0000_FFFF);
        settings_used++;
        send_frame(16'hFFFF, 16'h5A5A, 1'b0, 8, 0);
        send_item(OP_TICK, 8'hFF);
        send_item(OP_TICK, 8'h00);
        send_frame(16'd1, 16'hA5A5, 1'b0, 0, 0);
        repeat (3) send_item(OP_TICK, 8'($urandom));
        send_frame(16'd0, 16'h8001, 1'b0, 0, 0);
        wait_idle();
        write_reg(CFG_TIMEOUT, 32'd0);
        settings_used++;
        send_frame(16'd2, 16'h00FF, 1'b0, 0, 60);
    endtask

    // length against the limit at both extremes, one long payload
    task automatic test_length_limits();
        wait_idle();
        write_reg(CFG_MAXLEN, 32'd0);
        settings_used++;
        send_frame(16'd1, 16'h0001, 1'b0, 6, 0);
        send_frame(16'd0, 16'hFFFF, 1'b0, 0, 0);
        wait_idle();
        write_reg(CFG_MAXLEN, 32'h0000_FFFF);
        settings_used++;
        send_frame(16'd300, 16'hC3C5, 1'b0, 0, 2);
    endtask

    // random traffic under one setting, mostly well-formed frames
    task automatic random_phase(input int n_items, input logic [31:0] tmo,
                                input logic [15:0] maxlen, input bit idling);
        int          stop_at;
        int          pick;
        int          len_cap;
        int          cut;
        logic [15:0] len;
        bit          paused;
        wait_idle();
        write_reg(CFG_TIMEOUT, tmo);
        write_reg(CFG_MAXLEN, {16'h0000, maxlen});
        settings_used++;
        idle_on = idling;
        stop_at = items_sent + n_items;
        paused  = 1'b0;
        len_cap = (maxlen < 8) ? maxlen : 8;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                if ($urandom_range(9) == 0)
                    len = 16'($urandom_range(0, (maxlen < 40) ? maxlen : 40));
                else
                    len = 16'($urandom_range(0, len_cap));
                send_frame(len, 16'($urandom), $urandom_range(9) == 0, 0, 8);
            end else if (pick < 78 && maxlen != 16'hFFFF) begin
                len = 16'($urandom_range(int'(maxlen) + 1, 32'hFFFF));
                send_frame(len, 16'($urandom), 1'b0, 6, 8);
            end else if (pick < 88) begin
                // broken frame; without a timeout only cut inside the payload
                len = 16'($urandom_range(1, (len_cap < 1) ? 1 : len_cap));
                if (tmo == 32'd0) cut = $urandom_range(9, 8 + len);
                else cut = $urandom_range(1, 8 + len);
                send_frame(len, 16'($urandom), 1'b0, cut, 8);
            end else begin
                repeat ($urandom_range(1, 6))
                    send_item(1'($urandom_range(1)), 8'($urandom));
                if (tmo != 32'd0 && tmo < 32'd16)
                    repeat ($urandom_range(0, tmo + 2)) send_item(OP_TICK, 8'($urandom));
            end
            if (!paused && items_sent >= stop_at - n_items / 2) begin
                wait_idle();
                paused = 1'b1;
            end
        end
    endtask

    task automatic test_random_traffic();
        random_phase(250, 32'd1000, 16'd256, 1'b0);
        random_phase(300, 32'd6, 16'd16, 1'b1);
        random_phase(250, 32'd0, 16'hFFFF, 1'b1);
        random_phase(200, 32'hFFFF_FFFF, 16'd0, 1'b1);
        random_phase(200, 32'd2, 16'd8, 1'b1);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_config_frames();
        test_timeout_rules();
        test_length_limits();
        test_random_traffic();
        wait_idle();
        $display("%0d input transfers over %0d register settings", items_sent, settings_used);
        $display("results seen: %0d payload, %0d good, %0d bad sum, %0d too big, %0d timed out",
                 kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4]);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/sfr_pkg.sv
sv/sfr_front.sv
sv/sfr_queue.sv
sv/sfr_back.sv
sv/serial_frame_receiver_unit.sv
tb/testbench.sv
